/* sv/dcm_pkg.sv */
// Shared types and constants of the multichannel duty cycle meter.
`default_nettype none

package dcm_pkg;

    localparam int PIN_W      = 16;
    localparam int CH_W       = 4;
    localparam int RUN_W      = 31;
    localparam int EDGE_W     = 32;
    localparam int COMP_W     = 16;
    localparam int RATE_W     = 32;
    localparam int DUTY_W     = 10;
    localparam int FREQ_W     = 16;
    localparam int SUM_W      = RUN_W + 1;
    localparam int PROD_W     = SUM_W + DUTY_W;
    localparam int DIV_W      = SUM_W + FREQ_W;
    localparam int STEP_W     = $clog2(FREQ_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 64;

    localparam logic [DUTY_W-1:0] PERMILLE      = DUTY_W'(1000);
    localparam logic [FREQ_W-1:0] FREQ_MAX      = '1;
    localparam logic [RUN_W-1:0]  RUN_MAX       = '1;
    localparam logic [RUN_W-1:0]  STEADY_RESET  = RUN_W'(200000);
    localparam logic [RATE_W-1:0] RATE_RESET    = RATE_W'(200000);
    localparam logic [COMP_W-1:0] COMP_RESET    = '0;
    localparam logic [STEP_W-1:0] STEP_FIRST    = STEP_W'(FREQ_W);
    localparam logic [STEP_W-1:0] STEP_DUTY_TOP = STEP_W'(DUTY_W - 1);

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEADY = 2'd0,
        CFG_RATE   = 2'd1,
        CFG_COMP   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              level;
        logic [RUN_W-1:0]  run;
        logic [RUN_W-1:0]  lo;
        logic [RUN_W-1:0]  hi;
        logic [EDGE_W-1:0] edges;
    } lane_state_t;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] duty;
        logic [FREQ_W-1:0] freq;
    } div_res_t;

endpackage

`default_nettype wire

/* sv/dcm_lane.sv */
// One channel lane: edge detection, phase lengths, run and edge counters.
`default_nettype none

module dcm_lane
    import dcm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  tick_en,
    input  wire logic  pin,
    output lane_state_t state
);

    lane_state_t st_reg;
    lane_state_t st_next;

    always_comb begin
        st_next = st_reg;
        if (tick_en) begin
            if (pin != st_reg.level) begin
                st_next.level = pin;
                st_next.edges = st_reg.edges + EDGE_W'(1);
                if (pin) begin
                    st_next.lo = st_reg.run;
                end else begin
                    st_next.hi = st_reg.run;
                end
                st_next.run = RUN_W'(1);
            end else if (st_reg.run != RUN_MAX) begin
                st_next.run = st_reg.run + RUN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

    assign state = st_reg;

endmodule

`default_nettype wire

/* sv/dcm_div.sv */
// Shared restoring divider for duty permille and saturated frequency.
`default_nettype none

module dcm_div
    import dcm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RUN_W-1:0]  lo,
    input  wire logic [RUN_W-1:0]  hi,
    input  wire logic [COMP_W-1:0] comp,
    input  wire logic [RATE_W-1:0] rate,
    output div_res_t               res
);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_STEP = 4'b0100,
        D_DONE = 4'b1000
    } div_state_t;

    div_state_t        state_reg;
    div_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  clo_reg;
    logic [SUM_W-1:0]  den_reg;
    logic [RATE_W-1:0] num_f_reg;
    logic [PROD_W-1:0] rem_d_reg;
    logic [RATE_W-1:0] rem_f_reg;
    logic [DIV_W-1:0]  ds_reg;
    logic [DUTY_W-1:0] qd_reg;
    logic [FREQ_W-1:0] qf_reg;
    logic              sat_reg;
    logic              ge_f;
    logic              ge_d;

    assign ge_f = DIV_W'(rem_f_reg) >= ds_reg;
    assign ge_d = DIV_W'(rem_d_reg) >= ds_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_MUL;
            D_MUL:  state_next = D_STEP;
            D_STEP: if (step_reg == '0) state_next = D_DONE;
            D_DONE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    if (hi > RUN_W'(comp)) begin
                        clo_reg <= SUM_W'(lo) + SUM_W'(comp);
                    end else begin
                        clo_reg <= SUM_W'(lo);
                    end
                    den_reg   <= SUM_W'(lo) + SUM_W'(hi);
                    num_f_reg <= rate;
                end
            end
            D_MUL: begin
                rem_d_reg <= PROD_W'(clo_reg) * PROD_W'(PERMILLE);
                rem_f_reg <= num_f_reg;
                ds_reg    <= {den_reg, {FREQ_W{1'b0}}};
                step_reg  <= STEP_FIRST;
                qd_reg    <= '0;
                qf_reg    <= '0;
                sat_reg   <= 1'b0;
            end
            D_STEP: begin
                if (ge_f) begin
                    rem_f_reg <= RATE_W'(DIV_W'(rem_f_reg) - ds_reg);
                end
                if (step_reg == STEP_FIRST) begin
                    sat_reg <= ge_f;
                end else begin
                    qf_reg <= {qf_reg[FREQ_W-2:0], ge_f};
                end
                if (step_reg <= STEP_DUTY_TOP) begin
                    if (ge_d) begin
                        rem_d_reg <= PROD_W'(DIV_W'(rem_d_reg) - ds_reg);
                    end
                    qd_reg <= {qd_reg[DUTY_W-2:0], ge_d};
                end
                ds_reg   <= ds_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign res.done = (state_reg == D_DONE);
    assign res.duty = qd_reg;
    assign res.freq = sat_reg ? FREQ_MAX : qf_reg;

endmodule

`default_nettype wire

/* sv/multichannel_duty_cycle_meter_core.sv */
// Top level of the multichannel duty cycle meter: lanes, merge, divider, output register.
//
//  port group   dir   payload (lowest bits first)
//  s_*          in    tuser: op; tdata: pins[15:0], channel[19:16], zero pad[23:20]
//  m_*          out   tdata: read_channel[3:0], level[4], duty_permille[14:5],
//                            frequency_hz[30:15], edge_count[62:31], zero pad[63]
//  cfg_*        in    cfg_index 0 steady_limit, 1 sample_rate_hz, 2 edge_compensation
//
// A tick item leaves the meter ready for the next item; all lanes update in parallel.
// A read item on a steady or idle channel skips the divider; any other read waits for
// the divider, which resolves one quotient bit per cycle over 17 steps.
// No item is accepted while a read is in progress; a finished result waits in the
// output register while the next items are taken, and a later read holds in its
// last cycle until that register is free.
// Reset is synchronous on aresetn; it clears lanes and handshake state, presets config.
`default_nettype none

module multichannel_duty_cycle_meter_core
    import dcm_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // pins, channel, pad
    input  wire logic                  s_tuser,   // op
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [M_TDATA_W-1:0]  m_tdata,   // read_channel, level, duty, freq, edges, pad
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } top_state_t;

    top_state_t           state_reg;
    top_state_t           state_next;
    logic [RUN_W-1:0]     steady_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [COMP_W-1:0]    comp_reg;
    lane_state_t          lane_st [CHANNELS];
    logic [CHANNELS-1:0]  lane_pin;
    lane_state_t          sel;
    lane_state_t          snap_reg;
    logic [CH_W-1:0]      snap_ch_reg;
    logic [DUTY_W-1:0]    res_duty_reg;
    logic [FREQ_W-1:0]    res_freq_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 accept;
    logic                 tick_en;
    logic                 is_steady;
    logic                 out_free;
    logic                 div_start;
    div_res_t             div_res;
    logic [CH_W-1:0]      in_channel;

    assign in_channel = s_tdata[PIN_W +: CH_W];
    assign accept     = s_tvalid && s_tready;
    assign tick_en    = accept && (s_tuser == OP_TICK);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steady_reg <= STEADY_RESET;
            rate_reg   <= RATE_RESET;
            comp_reg   <= COMP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STEADY: steady_reg <= cfg_wdata[RUN_W-1:0];
                CFG_RATE:   rate_reg   <= cfg_wdata[RATE_W-1:0];
                CFG_COMP:   comp_reg   <= cfg_wdata[COMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        if (c < PIN_W) begin : g_pin
            assign lane_pin[c] = s_tdata[c];
        end else begin : g_nopin
            assign lane_pin[c] = 1'b0;
        end
        dcm_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tick_en (tick_en),
            .pin     (lane_pin[c]),
            .state   (lane_st[c])
        );
    end

    always_comb begin
        sel = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (int'(in_channel) == c) begin
                sel = lane_st[c];
            end
        end
    end

    assign is_steady = (snap_reg.run > steady_reg) || (snap_reg.lo == '0) ||
                       (snap_reg.hi == '0);
    assign div_start = (state_reg == ST_EVAL) && !is_steady;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && (s_tuser == OP_READ)) state_next = ST_EVAL;
            ST_EVAL: state_next = is_steady ? ST_EMIT : ST_DIV;
            ST_DIV:  if (div_res.done) state_next = ST_EMIT;
            ST_EMIT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == OP_READ)) begin
            snap_reg    <= sel;
            snap_ch_reg <= in_channel;
        end
        if ((state_reg == ST_EVAL) && is_steady) begin
            res_duty_reg <= snap_reg.level ? PERMILLE : '0;
            res_freq_reg <= '0;
        end else if ((state_reg == ST_DIV) && div_res.done) begin
            res_duty_reg <= div_res.duty;
            res_freq_reg <= div_res.freq;
        end
        if ((state_reg == ST_EMIT) && out_free) begin
            m_tdata_reg <= {1'b0, snap_reg.edges, res_freq_reg, res_duty_reg,
                            snap_reg.level, snap_ch_reg};
        end
    end

    dcm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .lo      (snap_reg.lo),
        .hi      (snap_reg.hi),
        .comp    (comp_reg),
        .rate    (rate_reg),
        .res     (div_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* sv/dcm_checker.sv */
// Port-level checks of the duty cycle meter, bound to the top level.
`default_nettype none

module dcm_checker
    import dcm_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:5] <= PERMILLE))
        else $error("duty above 1000 permille");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_READ) |=> !s_tready)
        else $error("item accepted during a read");

endmodule

bind multichannel_duty_cycle_meter_core dcm_checker u_dcm_checker (.*);

`default_nettype wire

/* test/multichannel_duty_cycle_meter_core_tb.sv */
// Self-checking testbench of the duty cycle meter: directed rows, then PWM-shaped random items.
`timescale 1ns / 100ps

module multichannel_duty_cycle_meter_core_tb
    import dcm_pkg::*;
;

    localparam int NCH          = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 32;
    localparam int PHASE_ITEMS  = 255;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [CH_W-1:0]   chan;
        logic              lvl;
        logic [DUTY_W-1:0] duty;
        logic [FREQ_W-1:0] freq;
        logic [EDGE_W-1:0] edges;
    } meter_reading_t;

    typedef struct packed {
        op_t              op;
        logic [PIN_W-1:0] pins;
        logic [CH_W-1:0]  chan;
        logic             typed;
        meter_reading_t   want;
    } directed_row_t;

    typedef struct packed {
        logic [RUN_W-1:0]  steady;
        logic [RATE_W-1:0] rate;
        logic [COMP_W-1:0] comp;
        logic [1:0]        idling;
    } phase_setup_t;

    localparam int NROWS   = 21;
    localparam int NPHASES = 6;

    localparam directed_row_t DIRECTED_ROWS [NROWS] = '{
        '{OP_READ, 16'h0000, 4'd0,  1'b1, '{4'd0,  1'b0, 10'd0,    16'd0,     32'd0}},
        '{OP_READ, 16'h0000, 4'd15, 1'b1, '{4'd15, 1'b0, 10'd0,    16'd0,     32'd0}},
        '{OP_TICK, 16'hFFFF, 4'd0,  1'b0, '0},
        '{OP_READ, 16'h0000, 4'd3,  1'b1, '{4'd3,  1'b1, 10'd1000, 16'd0,     32'd1}},
        '{OP_TICK, 16'h0000, 4'd0,  1'b0, '0},
        '{OP_READ, 16'h0000, 4'd15, 1'b1, '{4'd15, 1'b0, 10'd0,    16'd0,     32'd2}},
        '{OP_TICK, 16'hFFFF, 4'd0,  1'b0, '0},
        '{OP_READ, 16'h0000, 4'd7,  1'b1, '{4'd7,  1'b1, 10'd500,  16'd65535, 32'd3}},
        '{OP_TICK, 16'h0000, 4'd0,  1'b0, '0},
        '{OP_TICK, 16'h0000, 4'd0,  1'b0, '0},
        '{OP_TICK, 16'h0000, 4'd0,  1'b0, '0},
        '{OP_TICK, 16'h00FF, 4'd0,  1'b0, '0},
        '{OP_READ, 16'hFFFF, 4'd0,  1'b0, '0},
        '{OP_READ, 16'h0000, 4'd8,  1'b0, '0},
        '{OP_TICK, 16'h5555, 4'd0,  1'b0, '0},
        '{OP_TICK, 16'hAAAA, 4'd0,  1'b0, '0},
        '{OP_TICK, 16'h5555, 4'd0,  1'b0, '0},
        '{OP_READ, 16'h0000, 4'd1,  1'b0, '0},
        '{OP_READ, 16'h0000, 4'd2,  1'b0, '0},
        '{OP_TICK, 16'h1234, 4'd0,  1'b0, '0},
        '{OP_READ, 16'h0000, 4'd12, 1'b0, '0}
    };

    localparam phase_setup_t PHASES [NPHASES] = '{
        '{31'd50,         32'd1000,         16'd0,     2'd0},
        '{31'h7FFF_FFFF,  32'hFFFF_FFFF,    16'd3,     2'd1},
        '{31'd1,          32'd1,            16'hFFFF,  2'd2},
        '{31'd0,          32'd0,            16'd1,     2'd3},
        '{31'd30,         32'd12345,        16'd2,     2'd1},
        '{31'd200000,     32'd200000,       16'd5,     2'd3}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    multichannel_duty_cycle_meter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic              ch_level [NCH];
    logic [RUN_W-1:0]  ch_run   [NCH];
    logic [RUN_W-1:0]  ch_low   [NCH];
    logic [RUN_W-1:0]  ch_high  [NCH];
    logic [EDGE_W-1:0] ch_edges [NCH];
    logic [RUN_W-1:0]  cur_steady = STEADY_RESET;
    logic [RATE_W-1:0] cur_rate   = RATE_RESET;
    logic [COMP_W-1:0] cur_comp   = COMP_RESET;

    // PWM stimulus generators
    int   gen_lo   [NCH];
    int   gen_hi   [NCH];
    int   gen_left [NCH];
    logic gen_lvl  [NCH];

    meter_reading_t pending_readings [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int mismatches      = 0;
    int items_sent      = 0;
    int reads_sent      = 0;
    int readings_seen   = 0;
    int steady_reads    = 0;
    int comp_reads      = 0;
    int ceiling_reads   = 0;
    int settings_used   = 1;
    int cycles          = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d readings outstanding",
                     cycles, pending_readings.size());
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void advance_pins(logic [PIN_W-1:0] pins);
        for (int c = 0; c < NCH; c++) begin
            if (pins[c] != ch_level[c]) begin
                ch_level[c] = pins[c];
                ch_edges[c] = ch_edges[c] + EDGE_W'(1);
                if (pins[c])
                    ch_low[c] = ch_run[c];
                else
                    ch_high[c] = ch_run[c];
                ch_run[c] = RUN_W'(1);
            end else if (ch_run[c] != RUN_MAX) begin
                ch_run[c] = ch_run[c] + RUN_W'(1);
            end
        end
    endfunction

    function automatic meter_reading_t predict_reading(logic [CH_W-1:0] ch);
        meter_reading_t r;
        logic [63:0] lo, hi, clo, chi, q;
        r.chan  = ch;
        r.lvl   = ch_level[ch];
        r.edges = ch_edges[ch];
        lo = 64'(ch_low[ch]);
        hi = 64'(ch_high[ch]);
        if (ch_run[ch] > cur_steady || lo == 0 || hi == 0) begin
            r.duty = r.lvl ? PERMILLE : '0;
            r.freq = '0;
            steady_reads++;
        end else begin
            clo = lo;
            chi = hi;
            if (chi > 64'(cur_comp)) begin
                chi = chi - 64'(cur_comp);
                clo = clo + 64'(cur_comp);
                comp_reads++;
            end
            q = (clo * 64'(PERMILLE)) / (chi + clo);
            r.duty = q[DUTY_W-1:0];
            q = 64'(cur_rate) / (hi + lo);
            if (q > 64'(FREQ_MAX)) begin
                r.freq = FREQ_MAX;
                ceiling_reads++;
            end else begin
                r.freq = q[FREQ_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void retune(int c);
        if ($urandom_range(7) == 0) begin
            gen_lo[c] = $urandom_range(90, 30);
            gen_hi[c] = $urandom_range(90, 30);
        end else begin
            gen_lo[c] = $urandom_range(12, 1);
            gen_hi[c] = $urandom_range(12, 1);
        end
    endfunction

    function automatic logic [PIN_W-1:0] next_pwm_pins();
        logic [PIN_W-1:0] pins;
        for (int c = 0; c < NCH; c++) begin
            gen_left[c]--;
            if (gen_left[c] <= 0) begin
                gen_lvl[c]  = !gen_lvl[c];
                gen_left[c] = gen_lvl[c] ? gen_hi[c] : gen_lo[c];
            end
            pins[c] = gen_lvl[c];
        end
        return pins;
    endfunction

    task automatic push_item(op_t op, logic [PIN_W-1:0] pins, logic [CH_W-1:0] ch,
                             logic typed, meter_reading_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - PIN_W - CH_W){1'b0}}, ch, pins};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (op == OP_TICK) begin
            advance_pins(pins);
        end else begin
            reads_sent++;
            pending_readings.push_back(typed ? want : predict_reading(ch));
        end
    endtask

    task automatic drain_readings();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
    endtask

    task automatic write_settings(logic [RUN_W-1:0] steady, logic [RATE_W-1:0] rate,
                                  logic [COMP_W-1:0] comp);
        drain_readings();
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STEADY;
        cfg_wdata <= CFG_DATA_W'(steady);
        @(posedge aclk);
        cfg_index <= CFG_RATE;
        cfg_wdata <= rate;
        @(posedge aclk);
        cfg_index <= CFG_COMP;
        cfg_wdata <= CFG_DATA_W'(comp);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        cur_steady = steady;
        cur_rate   = rate;
        cur_comp   = comp;
        settings_used++;
    endtask

    always @(posedge aclk) begin
        meter_reading_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.chan  = m_tdata[3:0];
            got.lvl   = m_tdata[4];
            got.duty  = m_tdata[14:5];
            got.freq  = m_tdata[30:15];
            got.edges = m_tdata[62:31];
            readings_seen++;
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0d: unexpected reading ch %0d lvl %0d duty %0d freq %0d edges %0d",
                             cycles, got.chan, got.lvl, got.duty, got.freq, got.edges);
            end else begin
                want = pending_readings.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0d: expected ch %0d lvl %0d duty %0d freq %0d edges %0d",
                                 cycles, want.chan, want.lvl, want.duty, want.freq, want.edges);
                        $display("%0d:      got ch %0d lvl %0d duty %0d freq %0d edges %0d",
                                 cycles, got.chan, got.lvl, got.duty, got.freq, got.edges);
                    end
                end
            end
        end
    end

    initial begin
        logic [PIN_W-1:0] pins;
        for (int c = 0; c < NCH; c++) begin
            ch_level[c] = 1'b0;
            ch_run[c]   = '0;
            ch_low[c]   = '0;
            ch_high[c]  = '0;
            ch_edges[c] = '0;
            retune(c);
            gen_lvl[c]  = 1'b0;
            gen_left[c] = $urandom_range(12, 1);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i])
            push_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].pins, DIRECTED_ROWS[i].chan,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        foreach (PHASES[p]) begin
            write_settings(PHASES[p].steady, PHASES[p].rate, PHASES[p].comp);
            case (PHASES[p].idling)
                2'd0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                2'd1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2'd2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 97 == 50)
                    drain_readings();
                if ($urandom_range(99) == 0)
                    retune($urandom_range(NCH - 1));
                if ($urandom_range(99) < 30) begin
                    push_item(OP_READ, 16'($urandom), 4'($urandom_range(NCH - 1)), 1'b0, '0);
                end else begin
                    pins = next_pwm_pins();
                    if ($urandom_range(19) == 0)
                        pins = 16'($urandom);
                    else if ($urandom_range(9) == 0)
                        pins = pins ^ 16'($urandom);
                    push_item(OP_TICK, pins, 4'($urandom), 1'b0, '0);
                end
            end
        end

        drain_readings();
        repeat (SETTLE) @(posedge aclk);
        $display("Drove %0d items (%0d reads) under %0d register settings and four idling patterns",
                 items_sent, reads_sent, settings_used);
        $display("Compared %0d readings: %0d steady, %0d compensated, %0d at frequency ceiling",
                 readings_seen, steady_reads, comp_reads, ceiling_reads);
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d readings outstanding",
                     mismatches, pending_readings.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
